// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the timer table RTL.
// Both expect a clock named clk and a synchronous active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ostt_pkg.sv -----
// Package for the one-shot timer table: sizes, codes, payload and control structs.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ostt_pkg;

  // Table size and tick counter width
  localparam int CAPACITY  = 64;
  localparam int TICK_BITS = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Operation codes
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_SCHEDULED = 2'd0;
  localparam logic [1:0] KIND_FULL      = 2'd1;
  localparam logic [1:0] KIND_EXPIRED   = 2'd2;
  localparam logic [1:0] KIND_NONE      = 2'd3;

  // Input item
  typedef struct packed {
    logic        operation;
    logic [31:0] wait_ticks;
    logic [15:0] handler_id;
    logic [7:0]  task_tag;
  } req_t;

  // Result item
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] expired_handler;
    logic [7:0]  expired_task;
    logic        last;
  } rsp_t;

  // One table entry
  typedef struct packed {
    logic [TICK_BITS-1:0] wait_cnt;
    logic [TICK_BITS-1:0] start;
    logic                 started;
    logic [15:0]          handler;
    logic [7:0]           tag;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic sched;       // schedule item accepted: append entry or mark full
    logic tick_start;  // tick item accepted: bump counter, reset scan
    logic rd_en;       // read entry at scan pointer
    logic keep;        // entry not due: write back stamped, compact
    logic take;        // entry due: move it into the pending result
    logic fin_count;   // scan ends: table count takes the write pointer
    logic push_mid;    // pending result to output, not last
    logic push_last;   // pending result to output, last
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic table_empty;
    logic due;
    logic last_entry;
    logic have_pend;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/one_shot_timer_table.sv -----
// One-shot timer table, top level; depends on ostt_pkg, ostt_ctrl, ostt_datapath.
// Schedule: the result moves from the pending register to the output register in S_FINAL once it is free.
// Tick over N entries: one read and one evaluate state per entry, plus one hand-off (emit) state
// per expiry after the first, then the final state; output stalls hold the emit and final states.
// One item in flight; the next is accepted at the edge after the last result is registered.
// Reset clears tick counter and entry count; entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module one_shot_timer_table
  import ostt_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic req_valid,
  output logic       req_ready,
  input  wire  req_t req,
  output logic       rsp_valid,
  input  wire  logic rsp_ready,
  output rsp_t       rsp
);

  cmd_t cmd;
  sts_t sts;

  ostt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.operation),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ostt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/ostt_datapath.sv -----
// Datapath of the timer table: entry memory, tick counter, scan pointers,
// pending result and output register. Depends on ostt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ostt_datapath
  import ostt_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  req_t req,
  input  wire  cmd_t cmd,
  output sts_t       sts,
  input  wire  logic rsp_ready,
  output logic       rsp_valid,
  output rsp_t       rsp
);

  entry_t               mem [CAPACITY];
  entry_t               rdata;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     rd;
  logic [CNT_W-1:0]     w;
  logic [CNT_W-1:0]     w_next;
  logic [TICK_BITS-1:0] tick;
  logic                 have_pend;
  rsp_t                 pend;

  logic                 table_full;
  logic [TICK_BITS-1:0] start_eff;
  logic [TICK_BITS-1:0] due_at;
  entry_t               stamped;
  entry_t               new_entry;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wdata;

  // Entry evaluation: stamp if unstarted, then unsigned compare of the wrapped due time with the tick counter
  always_comb begin
    table_full        = (cnt == CNT_W'(CAPACITY));
    start_eff         = rdata.started ? rdata.start : tick;
    due_at            = start_eff + rdata.wait_cnt;
    stamped           = rdata;
    stamped.start     = start_eff;
    stamped.started   = 1'b1;
    new_entry.wait_cnt = TICK_BITS'(req.wait_ticks);
    new_entry.start   = '0;
    new_entry.started = 1'b0;
    new_entry.handler = req.handler_id;
    new_entry.tag     = req.task_tag;
    w_next            = cmd.keep ? w + 1'b1 : w;
  end

  // Memory write port: append on schedule, compacting write-back on scan
  always_comb begin
    we    = (cmd.sched && !table_full) || cmd.keep;
    waddr = cmd.keep ? w[IDX_W-1:0] : cnt[IDX_W-1:0];
    wdata = cmd.keep ? stamped : new_entry;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd[IDX_W-1:0]];
    end
  end

  // Control state: count, counter, scan pointers, pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      tick      <= '0;
      rd        <= '0;
      w         <= '0;
      have_pend <= 1'b0;
    end else begin
      if (cmd.sched && !table_full) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.tick_start) begin
        tick      <= tick + 1'b1;
        rd        <= '0;
        have_pend <= 1'b0;
      end
      if (cmd.keep || cmd.take) begin
        rd <= rd + 1'b1;
      end
      w <= cmd.tick_start ? '0 : w_next;
      if (cmd.take) begin
        have_pend <= 1'b1;
      end
      if (cmd.fin_count) begin
        cnt <= w_next;
      end
    end
  end

  // Pending result: kind of the current item, or the latest expired entry
  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      pend.result_kind     <= table_full ? KIND_FULL : KIND_SCHEDULED;
      pend.expired_handler <= '0;
      pend.expired_task    <= '0;
    end else if (cmd.tick_start) begin
      pend.result_kind     <= KIND_NONE;
      pend.expired_handler <= '0;
      pend.expired_task    <= '0;
    end else if (cmd.take) begin
      pend.result_kind     <= KIND_EXPIRED;
      pend.expired_handler <= rdata.handler;
      pend.expired_task    <= rdata.tag;
    end
    pend.last <= 1'b0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push_mid || cmd.push_last) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_mid || cmd.push_last) begin
      rsp.result_kind     <= pend.result_kind;
      rsp.expired_handler <= pend.expired_handler;
      rsp.expired_task    <= pend.expired_task;
      rsp.last            <= cmd.push_last;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.out_free    = !rsp_valid || rsp_ready;
    sts.table_empty = (cnt == '0);
    sts.due         = (due_at <= tick);
    sts.last_entry  = (CNT_W'(rd + 1'b1) == cnt);
    sts.have_pend   = have_pend;
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(CAPACITY), "entry count above capacity")
  `ASSERT_ALWAYS(a_w_behind_rd, w <= rd, "compaction pointer passed scan pointer")
  `ASSERT_ALWAYS(a_push_free, !(cmd.push_mid || cmd.push_last) || sts.out_free,
                 "result pushed into occupied output register")

endmodule

`default_nettype wire

// ----- rtl/ostt_ctrl.sv -----
// Controller of the timer table: one-hot state machine sequencing schedule,
// tick scan and result hand-off. Depends on ostt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ostt_ctrl
  import ostt_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic req_valid,
  input  wire  logic req_op,
  output logic       req_ready,
  input  wire  sts_t sts,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        // no item taken while in reset
        req_ready = !rst;
        if (req_valid && !rst) begin
          if (req_op == OP_SCHEDULE) begin
            cmd.sched  = 1'b1;
            state_next = S_FINAL;
          end else begin
            cmd.tick_start = 1'b1;
            state_next     = sts.table_empty ? S_FINAL : S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.due && sts.have_pend) begin
          // earlier expiry still pending: hand it out first
          state_next = S_EMIT;
        end else begin
          cmd.take      = sts.due;
          cmd.keep      = !sts.due;
          cmd.fin_count = sts.last_entry;
          state_next    = sts.last_entry ? S_FINAL : S_READ;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.push_mid  = 1'b1;
          cmd.take      = 1'b1;
          cmd.fin_count = sts.last_entry;
          state_next    = sts.last_entry ? S_FINAL : S_READ;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready,
               "second item accepted before the first finished")

endmodule

`default_nettype wire
